>>> rtl/svd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types and constants of the shear velocity dispersion core.
// ----------------------------------------------------------------------------
package svd_pkg;

   localparam logic [31:0] SHEAR_RESET = 32'd216770937;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHEAR,
      ST_AXIS,
      ST_DIV,
      ST_UPDATE,
      ST_MUL,
      ST_ACC,
      ST_NEXT,
      ST_VDIV,
      ST_SQRT,
      ST_ROOT_NEXT,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

>>> rtl/shear_velocity_dispersion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shear_velocity_dispersion_core
// Streams particles and keeps a Welford running variance for each of three
// velocity axes, the azimuthal one corrected for shear; the beat marked last
// yields the RMS dispersion per axis and the particle count.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload
//   req_      in         tdata {pos_x, vel_z, vel_y, vel_x}, tlast last_item
//   rsp_      out        tdata {overflow, count, sigma_z, sigma_y, sigma_x}
//   csr_      in         shear_rate write
//
// One beat is handled at a time. After acceptance a beat runs a bit-serial
// shear multiply, then per axis a 34-step restoring divider by the count, a
// 34-step bit-serial multiplier and set-up states, then a closing state. A
// beat that meets a full count skips the axes. A last beat adds per axis a
// divider, a square root and a closing state, plus an output state.
// The result waits in an output register while the next beat is taken; only
// a new result stalls while the previous one is not yet taken. Reset is
// synchronous and clears the statistics and restores shear_rate.
// ----------------------------------------------------------------------------
module shear_velocity_dispersion_core #(
   parameter int unsigned MAX_COUNT = 65536
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,  // vel_x, vel_y, vel_z, pos_x
   input  wire logic          req_tlast,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [119:0]       rsp_tdata,  // sigma_x, sigma_y, sigma_z, count[16:0],
                                          // overflow, zero fill
   input  wire logic          csr_we,
   input  wire logic [31:0]   csr_wdata
);
   import svd_pkg::*;

   localparam int unsigned CW = $clog2(MAX_COUNT + 1);

   state_type state_ff, state_in;
   logic [31:0]        shear_ff;
   logic [CW-1:0]      count_ff;
   logic               ovf_ff, last_ff, skip_ff;
   logic signed [31:0] mean_ff [3];
   logic [63:0]        ssum_ff [3];
   logic signed [31:0] val_ff [3];
   logic [1:0]         axis_ff;
   logic [6:0]         step_ff;
   // shared shift/accumulate working registers
   logic [63:0]        acc_ff, opa_ff;
   logic [32:0]        opb_ff;
   logic [63:0]        rem_ff;
   logic               neg_ff;
   logic signed [32:0] dold_ff;
   logic [31:0]        sig_ff [3];
   logic               out_v_ff;
   logic [119:0]       out_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   wire accept = req_tvalid && req_tready;
   wire out_free = !out_v_ff || rsp_tready;
   wire [CW-1:0] cnt_next = count_ff + CW'(1);
   wire [64:0] rem_try = {rem_ff[63:0], acc_ff[63]} - {33'd0, opb_ff[31:0]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept) state_in = ST_SHEAR;
         ST_SHEAR:     if (step_ff == 7'd32) state_in = skip_ff ? ST_NEXT : ST_AXIS;
         ST_AXIS:      state_in = ST_DIV;
         ST_DIV:       if (step_ff == 7'd33) state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_MUL;
         ST_MUL:       if (step_ff == 7'd33) state_in = ST_ACC;
         ST_ACC:       state_in = (axis_ff == 2'd2) ? ST_NEXT : ST_AXIS;
         ST_NEXT:      state_in = last_ff ? ST_VDIV : ST_IDLE;
         ST_VDIV:      if (step_ff == 7'd64) state_in = ST_SQRT;
         ST_SQRT:      if (step_ff == 7'd32) state_in = ST_ROOT_NEXT;
         ST_ROOT_NEXT: state_in = (axis_ff == 2'd2) ? ST_OUT : ST_VDIV;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         shear_ff <= SHEAR_RESET;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            mean_ff[i] <= '0;
            ssum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) shear_ff <= csr_wdata;
         if (rsp_tvalid && rsp_tready && state_ff != ST_OUT) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               val_ff[0] <= req_tdata[31:0];
               val_ff[1] <= req_tdata[63:32];
               val_ff[2] <= req_tdata[95:64];
               last_ff   <= req_tlast;
               skip_ff   <= (32'(count_ff) >= 32'(MAX_COUNT));
               if (32'(count_ff) >= 32'(MAX_COUNT)) ovf_ff <= 1'b1;
               else count_ff <= cnt_next;
               // |pos_x| times shear, one multiplier bit a step
               neg_ff  <= req_tdata[127];
               opa_ff  <= {32'd0, req_tdata[127] ? 32'(-req_tdata[127:96])
                                                 : req_tdata[127:96]};
               opb_ff  <= {1'b0, shear_ff};
               acc_ff  <= '0;
               step_ff <= '0;
               axis_ff <= 2'd0;
            end
            ST_SHEAR: begin
               if (step_ff == 7'd32) begin : fin
                  logic [63:0] q;
                  logic signed [33:0] sum;
                  // floor for negative: -ceil(mag/2^40)
                  q = acc_ff >> 40;
                  if (neg_ff && acc_ff[39:0] != 40'd0) q = q + 64'd1;
                  sum = 34'(val_ff[1]) + (neg_ff ? -34'(q[24:0]) : 34'(q[24:0]));
                  if (sum > 34'sd2147483647) val_ff[1] <= 32'h7fffffff;
                  else if (sum < -34'sd2147483648) val_ff[1] <= 32'h80000000;
                  else val_ff[1] <= sum[31:0];
               end else begin
                  if (opb_ff[0]) acc_ff <= acc_ff + opa_ff;
                  opa_ff <= opa_ff << 1;
                  opb_ff <= opb_ff >> 1;
               end
               step_ff <= step_ff + 7'd1;
            end
            ST_AXIS: begin : ax
               logic signed [32:0] d;
               d = 33'(val_ff[axis_ff]) - 33'(mean_ff[axis_ff]);
               dold_ff <= d;
               neg_ff  <= d[32];
               // 34-bit dividend with a zero on top, one bit per divider step
               acc_ff  <= {31'd0, d[32] ? -d : d} << 30;
               rem_ff  <= '0;
               opb_ff  <= 33'(count_ff);
               step_ff <= '0;
            end
            ST_DIV: begin
               // restoring divide, quotient bits shift into acc low end
               if (!rem_try[64]) rem_ff <= rem_try[63:0];
               else rem_ff <= {rem_ff[62:0], acc_ff[63]};
               acc_ff <= {acc_ff[62:0], !rem_try[64]};
               step_ff <= step_ff + 7'd1;
            end
            ST_UPDATE: begin : up
               logic signed [32:0] nm, dn;
               nm = 33'(mean_ff[axis_ff]) + (neg_ff ? -33'(acc_ff[32:0])
                                                    : 33'(acc_ff[32:0]));
               mean_ff[axis_ff] <= nm[31:0];
               dn = 33'(val_ff[axis_ff]) - nm;
               opa_ff  <= {31'd0, dold_ff[32] ? -dold_ff : dold_ff};
               opb_ff  <= dn[32] ? -dn : dn;
               acc_ff  <= '0;
               step_ff <= '0;
            end
            ST_MUL: begin
               if (opb_ff[0]) acc_ff <= acc_ff + opa_ff;
               opa_ff  <= opa_ff << 1;
               opb_ff  <= opb_ff >> 1;
               step_ff <= step_ff + 7'd1;
            end
            ST_ACC: begin : ac
               logic [64:0] s;
               s = {1'b0, ssum_ff[axis_ff]} + {1'b0, acc_ff};
               ssum_ff[axis_ff] <= s[64] ? '1 : s[63:0];
               axis_ff <= axis_ff + 2'd1;
            end
            ST_NEXT: begin
               axis_ff <= 2'd0;
               acc_ff  <= ssum_ff[0];
               rem_ff  <= '0;
               opb_ff  <= 33'(count_ff);
               step_ff <= '0;
            end
            ST_VDIV: begin
               if (step_ff == 7'd64) begin
                  // acc holds the variance; set up root
                  rem_ff  <= '0;
                  opa_ff  <= '0;
                  step_ff <= '0;
               end else begin
                  if (!rem_try[64]) rem_ff <= rem_try[63:0];
                  else rem_ff <= {rem_ff[62:0], acc_ff[63]};
                  acc_ff <= {acc_ff[62:0], !rem_try[64]};
                  step_ff <= step_ff + 7'd1;
               end
            end
            ST_SQRT: begin
               if (step_ff != 7'd32) begin : sq
                  logic [65:0] r, t;
                  r = {rem_ff[63:0], acc_ff[63:62]};
                  t = {opa_ff[31:0], 2'b01};
                  if (r >= t) begin
                     rem_ff <= 64'(r - t);
                     opa_ff <= {opa_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= r[63:0];
                     opa_ff <= {opa_ff[62:0], 1'b0};
                  end
                  acc_ff <= acc_ff << 2;
               end
               step_ff <= step_ff + 7'd1;
            end
            ST_ROOT_NEXT: begin
               sig_ff[axis_ff] <= opa_ff[31:0];
               axis_ff <= axis_ff + 2'd1;
               acc_ff  <= ssum_ff[(axis_ff == 2'd0) ? 2'd1 : 2'd2];
               rem_ff  <= '0;
               step_ff <= '0;
            end
            ST_OUT: if (out_free) begin
               out_ff   <= {6'd0, ovf_ff, 17'(count_ff), sig_ff[2], sig_ff[1], sig_ff[0]};
               out_v_ff <= 1'b1;
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               for (int i = 0; i < 3; i++) begin
                  mean_ff[i] <= '0;
                  ssum_ff[i] <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/svd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_checker
// Port-level checks of the shear velocity dispersion core.
// ----------------------------------------------------------------------------
module svd_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [119:0] rsp_tdata
);
   // The fill above the overflow flag is always zero.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[119:114] == 6'd0) else $error("nonzero fill");
   // Results hold while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // A result reports at least one particle.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[116:96] != 21'd0 || rsp_tdata[113] )
      else $error("empty count");
   // After an accepted beat the block is busy.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");
endmodule

bind shear_velocity_dispersion_core svd_checker u_svd_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
